>>> sv/rpr_pkg.sv
// Shared widths, constants and types of the relative pose transform.
`default_nettype none

package rpr_pkg;

    // Field widths at the ports.
    localparam int PW   = 32;   // position, signed Q15.16
    localparam int QW   = 16;   // quaternion part, signed Q1.14
    localparam int QVW  = 4 * QW;

    // Internal widths.
    localparam int DW   = PW + 1;       // exact position difference
    localparam int DLW  = 16;           // low half of the difference, unsigned
    localparam int DHW  = DW - DLW;     // high half of the difference, signed
    localparam int PRW  = 2 * QW;       // product of two quaternion parts
    localparam int MW   = PRW + 2;      // matrix entry or quaternion sum, Q.28
    localparam int PPW  = MW + DHW;     // matrix entry times one half of a difference
    localparam int SUMW = PPW + 2;      // sum of three partial products
    localparam int ACCW = SUMW + DLW + 1;

    // Fraction bits of the matrix entries and quaternion products.
    localparam int MAT_FRAC = 28;
    localparam int QFRAC    = 14;

    // Number of register stages from request to result.
    localparam int NSTG = 5;

    localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [QW-1:0] QP_MAX  = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] QP_MIN  = {1'b1, {(QW-1){1'b0}}};

    typedef logic signed [PW-1:0]   pos_t;
    typedef logic signed [QW-1:0]   qpart_t;
    typedef logic signed [DW-1:0]   diff_t;
    typedef logic signed [DHW-1:0]  dh_t;
    typedef logic        [DLW-1:0]  dl_t;
    typedef logic signed [PRW-1:0]  prod_t;
    typedef logic signed [MW-1:0]   mat_t;
    typedef logic signed [PPW-1:0]  pp_t;
    typedef logic signed [SUMW-1:0] psum_t;

    // Load enables of the stages that the row dot product units hold.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } dot_en_t;

endpackage

`default_nettype wire

>>> sv/rpr_pose_if.sv
// Request channel carrying a reference pose and a target pose.
`default_nettype none

interface rpr_pose_if import rpr_pkg::*; ();

    logic               valid;
    logic               ready;
    pos_t               ref_pos_x;
    pos_t               ref_pos_y;
    pos_t               ref_pos_z;
    logic [QVW-1:0]     ref_quat;
    pos_t               tgt_pos_x;
    pos_t               tgt_pos_y;
    pos_t               tgt_pos_z;
    logic [QVW-1:0]     tgt_quat;

    modport source (
        output valid, ref_pos_x, ref_pos_y, ref_pos_z, ref_quat,
               tgt_pos_x, tgt_pos_y, tgt_pos_z, tgt_quat,
        input  ready
    );

    modport sink (
        input  valid, ref_pos_x, ref_pos_y, ref_pos_z, ref_quat,
               tgt_pos_x, tgt_pos_y, tgt_pos_z, tgt_quat,
        output ready
    );

endinterface

`default_nettype wire

>>> sv/rpr_rel_if.sv
// Result channel carrying the target pose in the reference frame.
`default_nettype none

interface rpr_rel_if import rpr_pkg::*; ();

    logic               valid;
    logic               ready;
    pos_t               rel_pos_x;
    pos_t               rel_pos_y;
    pos_t               rel_pos_z;
    logic [QVW-1:0]     rel_quat;
    logic               saturated;

    modport source (
        output valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_quat, saturated,
        input  ready
    );

    modport sink (
        input  valid, rel_pos_x, rel_pos_y, rel_pos_z, rel_quat, saturated,
        output ready
    );

endinterface

`default_nettype wire

>>> sv/relative_pose_to_reference_frame.sv
// Relative pose transform: target pose expressed in the frame of a reference pose.
//
// The pose channel takes one request: a reference and a target position
// (signed Q15.16) and orientation quaternion (signed Q1.14, w in the top
// bits). The rel channel returns the target position rotated by the
// transposed rotation of the reference quaternion after subtracting the
// reference position, and the conjugate of the reference quaternion times
// the target quaternion. Every part is rounded to nearest and clipped;
// saturated is high when any part was clipped.
// Both channels use valid and ready; a request or a result moves at a
// clock edge where both are high.
// The datapath is five register stages deep, numbered 0 to 4, and a result
// is offered from stage 4. One request is taken every cycle while the
// receiver keeps ready high. Each stage holds one multiplier or one adder
// level of the rotation and quaternion product.
// When the receiver stalls, the final stage holds its result and earlier
// stages keep filling their empty slots, so ready on the pose channel
// drops only once every stage is occupied.
// Reset empties the pipeline; the block keeps no other state.
`default_nettype none

module relative_pose_to_reference_frame import rpr_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    rpr_pose_if.sink        pose,
    rpr_rel_if.source       rel
);

    localparam int QBW = MW + 1;
    localparam int QRW = QBW - QFRAC;
    localparam logic signed [QBW-1:0] QBIAS   = QBW'(2 ** (QFRAC - 1));
    localparam logic signed [MW-1:0]  ONE_Q28 = MW'(2 ** MAT_FRAC);

    // Quaternion part indexes.
    localparam int QI_W = 0;
    localparam int QI_X = 1;
    localparam int QI_Y = 2;
    localparam int QI_Z = 3;

    // Stage occupancy and load enables.
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] en;

    // Stage 0 registers.
    diff_t d_reg [3];
    prod_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    prod_t h_reg [4][4];

    // Stage 1 registers.
    mat_t  m_reg [3][3];
    mat_t  m_next [3][3];
    mat_t  q_reg [4];
    mat_t  q_next [4];
    dh_t   dh_reg [3];
    dl_t   dl_reg [3];

    // Stage 2 to 4 registers of the quaternion path.
    qpart_t qp2_reg [4];
    qpart_t qp3_reg [4];
    qpart_t qp4_reg [4];
    qpart_t qp_next [4];
    logic   qsat2_reg, qsat3_reg, qsat4_reg;
    logic   qsat_next;

    logic signed [QBW-1:0] q_biased [4];
    logic signed [QRW-1:0] q_rnd [4];

    qpart_t  rq [4];
    qpart_t  tq [4];
    diff_t   d_next [3];
    pos_t    row_pos [3];
    logic    row_sat [3];
    dot_en_t dot_en;

    function automatic mat_t sx(input prod_t p);
        sx = MW'(p);
    endfunction

    // Stage enables: a stage loads when it is empty or its successor loads.
    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || rel.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= pose.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign pose.ready = en[0];

    // Unpack the quaternions and form the exact position differences.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rq[i] = pose.ref_quat[QVW-1-QW*i -: QW];
            tq[i] = pose.tgt_quat[QVW-1-QW*i -: QW];
        end
        d_next[0] = DW'(pose.tgt_pos_x) - DW'(pose.ref_pos_x);
        d_next[1] = DW'(pose.tgt_pos_y) - DW'(pose.ref_pos_y);
        d_next[2] = DW'(pose.tgt_pos_z) - DW'(pose.ref_pos_z);
    end

    // Stage 0: all quaternion products and the exact position differences.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg  <= d_next;
            xx_reg <= rq[QI_X] * rq[QI_X];
            yy_reg <= rq[QI_Y] * rq[QI_Y];
            zz_reg <= rq[QI_Z] * rq[QI_Z];
            xy_reg <= rq[QI_X] * rq[QI_Y];
            xz_reg <= rq[QI_X] * rq[QI_Z];
            yz_reg <= rq[QI_Y] * rq[QI_Z];
            wx_reg <= rq[QI_W] * rq[QI_X];
            wy_reg <= rq[QI_W] * rq[QI_Y];
            wz_reg <= rq[QI_W] * rq[QI_Z];
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    h_reg[i][j] <= rq[i] * tq[j];
                end
            end
        end
    end

    // Stage 1: rows of the transposed rotation and the conjugate product sums.
    always_comb
    begin
        m_next[0][0] = ONE_Q28 - ((sx(yy_reg) + sx(zz_reg)) <<< 1);
        m_next[0][1] = (sx(xy_reg) + sx(wz_reg)) <<< 1;
        m_next[0][2] = (sx(xz_reg) - sx(wy_reg)) <<< 1;
        m_next[1][0] = (sx(xy_reg) - sx(wz_reg)) <<< 1;
        m_next[1][1] = ONE_Q28 - ((sx(xx_reg) + sx(zz_reg)) <<< 1);
        m_next[1][2] = (sx(yz_reg) + sx(wx_reg)) <<< 1;
        m_next[2][0] = (sx(xz_reg) + sx(wy_reg)) <<< 1;
        m_next[2][1] = (sx(yz_reg) - sx(wx_reg)) <<< 1;
        m_next[2][2] = ONE_Q28 - ((sx(xx_reg) + sx(yy_reg)) <<< 1);

        q_next[QI_W] = sx(h_reg[QI_W][QI_W]) + sx(h_reg[QI_X][QI_X])
                     + sx(h_reg[QI_Y][QI_Y]) + sx(h_reg[QI_Z][QI_Z]);
        q_next[QI_X] = sx(h_reg[QI_W][QI_X]) - sx(h_reg[QI_X][QI_W])
                     - sx(h_reg[QI_Y][QI_Z]) + sx(h_reg[QI_Z][QI_Y]);
        q_next[QI_Y] = sx(h_reg[QI_W][QI_Y]) + sx(h_reg[QI_X][QI_Z])
                     - sx(h_reg[QI_Y][QI_W]) - sx(h_reg[QI_Z][QI_X]);
        q_next[QI_Z] = sx(h_reg[QI_W][QI_Z]) - sx(h_reg[QI_X][QI_Y])
                     + sx(h_reg[QI_Y][QI_X]) - sx(h_reg[QI_Z][QI_W]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            m_reg <= m_next;
            q_reg <= q_next;
            for (int i = 0; i < 3; i++)
            begin
                dh_reg[i] <= d_reg[i][DW-1:DLW];
                dl_reg[i] <= d_reg[i][DLW-1:0];
            end
        end
    end

    // Stage 2 of the quaternion path: round to Q1.14 and clip.
    always_comb
    begin
        qsat_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            q_biased[i] = QBW'(q_reg[i]) + QBIAS;
            q_rnd[i]    = q_biased[i][QBW-1:QFRAC];
            if (q_rnd[i][QRW-1:QW-1] != {(QRW-QW+1){q_rnd[i][QW-1]}})
            begin
                qsat_next  = 1'b1;
                qp_next[i] = q_rnd[i][QRW-1] ? QP_MIN : QP_MAX;
            end
            else
            begin
                qp_next[i] = q_rnd[i][QW-1:0];
            end
        end
    end

    // Carry the quaternion result alongside the position rows.
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            qp2_reg   <= qp_next;
            qsat2_reg <= qsat_next;
        end
        if (en[3])
        begin
            qp3_reg   <= qp2_reg;
            qsat3_reg <= qsat2_reg;
        end
        if (en[4])
        begin
            qp4_reg   <= qp3_reg;
            qsat4_reg <= qsat3_reg;
        end
    end

    // Stages 2 to 4 of the position path, one unit per output axis.
    assign dot_en = '{s2: en[2], s3: en[3], s4: en[4]};

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        rpr_row_dot u_row (
            .clk (clk),
            .en  (dot_en),
            .m   (m_reg[r]),
            .dh  (dh_reg),
            .dl  (dl_reg),
            .pos (row_pos[r]),
            .sat (row_sat[r])
        );
    end

    // Result channel.
    assign rel.valid     = valid_reg[NSTG-1];
    assign rel.rel_pos_x = row_pos[0];
    assign rel.rel_pos_y = row_pos[1];
    assign rel.rel_pos_z = row_pos[2];
    assign rel.rel_quat  = {qp4_reg[QI_W], qp4_reg[QI_X], qp4_reg[QI_Y], qp4_reg[QI_Z]};
    assign rel.saturated = qsat4_reg | row_sat[0] | row_sat[1] | row_sat[2];

    // A taken request occupies the first stage.
    a_take_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        pose.valid && pose.ready |=> valid_reg[0])
        else $error("accepted request did not enter the first stage");

    // A blocked middle stage keeps its item.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && !en[2] |=> valid_reg[2])
        else $error("stalled stage dropped its item");

    // An item moving out of the next to last stage reaches the result.
    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NSTG-2] && en[NSTG-1] |=> rel.valid)
        else $error("item lost before the result stage");

    // A clipped x position sits at one end of the range.
    a_clip_x: assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid && row_sat[0] |-> (row_pos[0] == POS_MAX || row_pos[0] == POS_MIN))
        else $error("clipped x position is not at a range limit");

endmodule

`default_nettype wire

>>> sv/rpr_row_dot.sv
// One row of the transposed rotation times the position difference, three stages.
`default_nettype none

module rpr_row_dot import rpr_pkg::*; (
    input  logic    clk,
    input  dot_en_t en,
    input  mat_t    m [3],
    input  dh_t     dh [3],
    input  dl_t     dl [3],
    output pos_t    pos,
    output logic    sat
);

    localparam int RW = ACCW - MAT_FRAC;
    localparam logic signed [ACCW-1:0] RND_BIAS = ACCW'(2 ** (MAT_FRAC - 1));

    pp_t   ph_reg [3];
    pp_t   pl_reg [3];
    psum_t sh_reg;
    psum_t sl_reg;
    pos_t  pos_reg;
    pos_t  pos_next;
    logic  sat_reg;
    logic  sat_next;

    logic signed [ACCW-1:0] acc;
    logic signed [RW-1:0]   rnd;

    // Partial products against the high and low halves of each difference.
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ph_reg[i] <= pp_t'(m[i]) * pp_t'(dh[i]);
                pl_reg[i] <= pp_t'(m[i]) * pp_t'($signed({1'b0, dl[i]}));
            end
        end
    end

    // Sum the three terms of each half.
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            sh_reg <= SUMW'(ph_reg[0]) + SUMW'(ph_reg[1]) + SUMW'(ph_reg[2]);
            sl_reg <= SUMW'(pl_reg[0]) + SUMW'(pl_reg[1]) + SUMW'(pl_reg[2]);
        end
    end

    // Join the halves, round to nearest with ties upward, and clip to 32 bits.
    always_comb
    begin
        acc      = (ACCW'(sh_reg) <<< DLW) + ACCW'(sl_reg) + RND_BIAS;
        rnd      = acc[ACCW-1:MAT_FRAC];
        sat_next = (rnd[RW-1:PW-1] != {(RW-PW+1){rnd[PW-1]}});
        if (sat_next)
        begin
            pos_next = rnd[RW-1] ? POS_MIN : POS_MAX;
        end
        else
        begin
            pos_next = rnd[PW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            pos_reg <= pos_next;
            sat_reg <= sat_next;
        end
    end

    assign pos = pos_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

>>> sim/rpr_tb_pkg.sv
// Request and result records, expected-pose calculation and scoreboard for the pose transform bench.
package rpr_tb_pkg;

    import rpr_pkg::*;

    // One pose pair as it travels on the pose channel.
    typedef struct {
        pos_t           ref_pos_x;
        pos_t           ref_pos_y;
        pos_t           ref_pos_z;
        logic [QVW-1:0] ref_quat;
        pos_t           tgt_pos_x;
        pos_t           tgt_pos_y;
        pos_t           tgt_pos_z;
        logic [QVW-1:0] tgt_quat;
    } pose_req_t;

    // One relative pose as it travels on the rel channel.
    typedef struct {
        pos_t           rel_pos_x;
        pos_t           rel_pos_y;
        pos_t           rel_pos_z;
        logic [QVW-1:0] rel_quat;
        logic           saturated;
    } rel_pose_t;

    localparam longint ONE_Q28  = longint'(1) << MAT_FRAC;
    localparam longint HALF_Q14 = longint'(1) << (QFRAC - 1);
    localparam logic signed [95:0] HALF_Q28 = 96'sd134217728;

    // Packs four quaternion parts, w in the top bits.
    function automatic logic [QVW-1:0] quat4(input qpart_t w, input qpart_t x,
                                            input qpart_t y, input qpart_t z);
        return {w, x, y, z};
    endfunction

    // Computes the target pose in the reference frame with exact wide arithmetic.
    function automatic rel_pose_t predict_rel_pose(input pose_req_t p);
        longint rw, rx, ry, rz, tw, tx, ty, tz;
        longint diff [3];
        longint rot_t [3][3];
        longint qprod [4];
        longint qr;
        logic signed [95:0] acc, term_m, term_d;
        pos_t pos_res [3];
        qpart_t qp_res [4];
        rel_pose_t r;

        r.saturated = 1'b0;
        rw = qpart_t'(p.ref_quat[63:48]);
        rx = qpart_t'(p.ref_quat[47:32]);
        ry = qpart_t'(p.ref_quat[31:16]);
        rz = qpart_t'(p.ref_quat[15:0]);
        tw = qpart_t'(p.tgt_quat[63:48]);
        tx = qpart_t'(p.tgt_quat[47:32]);
        ty = qpart_t'(p.tgt_quat[31:16]);
        tz = qpart_t'(p.tgt_quat[15:0]);

        diff[0] = longint'(p.tgt_pos_x) - longint'(p.ref_pos_x);
        diff[1] = longint'(p.tgt_pos_y) - longint'(p.ref_pos_y);
        diff[2] = longint'(p.tgt_pos_z) - longint'(p.ref_pos_z);

        // Transposed rotation matrix of the reference quaternion, Q.28.
        rot_t[0][0] = ONE_Q28 - 2 * (ry * ry + rz * rz);
        rot_t[0][1] = 2 * (rx * ry + rw * rz);
        rot_t[0][2] = 2 * (rx * rz - rw * ry);
        rot_t[1][0] = 2 * (rx * ry - rw * rz);
        rot_t[1][1] = ONE_Q28 - 2 * (rx * rx + rz * rz);
        rot_t[1][2] = 2 * (ry * rz + rw * rx);
        rot_t[2][0] = 2 * (rx * rz + rw * ry);
        rot_t[2][1] = 2 * (ry * rz - rw * rx);
        rot_t[2][2] = ONE_Q28 - 2 * (rx * rx + ry * ry);

        // Full Q.44 dot product per row, then round half up to Q.16 and clip.
        for (int i = 0; i < 3; i++)
        begin
            acc = '0;
            for (int j = 0; j < 3; j++)
            begin
                term_m = rot_t[i][j];
                term_d = diff[j];
                acc = acc + term_m * term_d;
            end
            acc = (acc + HALF_Q28) >>> MAT_FRAC;
            if (acc > POS_MAX)
            begin
                pos_res[i] = POS_MAX;
                r.saturated = 1'b1;
            end
            else if (acc < POS_MIN)
            begin
                pos_res[i] = POS_MIN;
                r.saturated = 1'b1;
            end
            else
            begin
                pos_res[i] = acc[PW-1:0];
            end
        end

        // Conjugate of the reference times the target, Hamilton product.
        qprod[0] = rw * tw + rx * tx + ry * ty + rz * tz;
        qprod[1] = rw * tx - rx * tw - ry * tz + rz * ty;
        qprod[2] = rw * ty + rx * tz - ry * tw - rz * tx;
        qprod[3] = rw * tz - rx * ty + ry * tx - rz * tw;

        for (int k = 0; k < 4; k++)
        begin
            qr = (qprod[k] + HALF_Q14) >>> QFRAC;
            if (qr > longint'(QP_MAX))
            begin
                qp_res[k] = QP_MAX;
                r.saturated = 1'b1;
            end
            else if (qr < longint'(QP_MIN))
            begin
                qp_res[k] = QP_MIN;
                r.saturated = 1'b1;
            end
            else
            begin
                qp_res[k] = qr[QW-1:0];
            end
        end

        r.rel_pos_x = pos_res[0];
        r.rel_pos_y = pos_res[1];
        r.rel_pos_z = pos_res[2];
        r.rel_quat  = {qp_res[0], qp_res[1], qp_res[2], qp_res[3]};
        return r;
    endfunction

    // Keeps the relative poses still owed by the block, oldest first.
    class rel_pose_scoreboard;

        rel_pose_t   expected_rel [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_request(input pose_req_t p);
            expected_rel.push_back(predict_rel_pose(p));
        endfunction

        function int unsigned pending();
            return expected_rel.size();
        endfunction

        function void compare_field(input string field, input logic [63:0] want,
                                    input logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input rel_pose_t got);
            rel_pose_t want;
            if (expected_rel.size() == 0)
            begin
                $error("relative pose returned with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_rel.pop_front();
            compare_field("rel_pos_x", 64'(want.rel_pos_x), 64'(got.rel_pos_x));
            compare_field("rel_pos_y", 64'(want.rel_pos_y), 64'(got.rel_pos_y));
            compare_field("rel_pos_z", 64'(want.rel_pos_z), 64'(got.rel_pos_z));
            compare_field("rel_quat", want.rel_quat, got.rel_quat);
            compare_field("saturated", 64'(want.saturated), 64'(got.saturated));
        endfunction

    endclass

    // Random position: moderate in half the draws, otherwise full range, a rail, zero or minus one.
    function automatic pos_t rand_pos();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return pos_t'($urandom);
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return POS_MAX;
                    1: return POS_MIN;
                    2: return pos_t'(0);
                    default: return pos_t'(-1);
                endcase
            end
            5, 6: return pos_t'($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
            default: return pos_t'($urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
        endcase
    endfunction

    // Small motion of a tracked target around its reference, within +-4.0.
    function automatic pos_t near_offset();
        return pos_t'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
    endfunction

    function automatic qpart_t rand_part(input bit unit_scale);
        if (unit_scale)
            return qpart_t'($urandom_range(0, 32768) - 16384);
        case ($urandom_range(0, 9))
            0: return QP_MAX;
            1: return QP_MIN;
            2: return qpart_t'(0);
            3: return qpart_t'(-1);
            default: return qpart_t'($urandom);
        endcase
    endfunction

    function automatic logic [QVW-1:0] rand_quat(input bit unit_scale);
        return {rand_part(unit_scale), rand_part(unit_scale),
                rand_part(unit_scale), rand_part(unit_scale)};
    endfunction

    // Mostly tracker-like pose pairs, the rest with independent random positions and unrestricted quaternion parts.
    function automatic pose_req_t random_pose_pair();
        pose_req_t p;
        bit tracked;
        tracked = ($urandom_range(0, 9) < 7);
        p.ref_pos_x = rand_pos();
        p.ref_pos_y = rand_pos();
        p.ref_pos_z = rand_pos();
        p.ref_quat  = rand_quat(tracked);
        p.tgt_quat  = rand_quat(tracked);
        p.tgt_pos_x = tracked ? pos_t'(p.ref_pos_x + near_offset()) : rand_pos();
        p.tgt_pos_y = tracked ? pos_t'(p.ref_pos_y + near_offset()) : rand_pos();
        p.tgt_pos_z = tracked ? pos_t'(p.ref_pos_z + near_offset()) : rand_pos();
        return p;
    endfunction

endpackage

>>> sim/tb.sv
// Top-level bench of the relative pose transform: clock, reset, request driver and result checker.
module tb;

    import rpr_pkg::*;
    import rpr_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS      = 1735;
    localparam int unsigned DRAIN_AT          = 500;
    localparam int unsigned HOLD_AT           = 900;
    localparam int unsigned LONG_HOLD_CYCLES  = 250;
    localparam int unsigned TAIL_CYCLES       = 4 * NSTG;
    localparam int unsigned LIMIT_CYCLES      = 400000;
    localparam qpart_t      QONE              = 16'sd16384;
    localparam pos_t        PONE              = 32'sh0001_0000;

    typedef enum int unsigned {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

    logic clk = 1'b0;
    logic rst_n;
    bit   long_hold_req = 1'b0;
    int unsigned cycle_count = 0;

    rel_pose_scoreboard sb;

    rpr_pose_if pose_ch ();
    rpr_rel_if  rel_ch ();

    relative_pose_to_reference_frame dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pose  (pose_ch),
        .rel   (rel_ch)
    );

    // Free-running clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic drive_payload(input pose_req_t r);
        pose_ch.ref_pos_x <= r.ref_pos_x;
        pose_ch.ref_pos_y <= r.ref_pos_y;
        pose_ch.ref_pos_z <= r.ref_pos_z;
        pose_ch.ref_quat  <= r.ref_quat;
        pose_ch.tgt_pos_x <= r.tgt_pos_x;
        pose_ch.tgt_pos_y <= r.tgt_pos_y;
        pose_ch.tgt_pos_z <= r.tgt_pos_z;
        pose_ch.tgt_quat  <= r.tgt_quat;
    endtask

    // Offers one request and returns at the edge where it is taken.
    task automatic send_request(input pose_req_t r);
        pose_ch.valid <= 1'b1;
        drive_payload(r);
        do
            @(negedge clk);
        while (!pose_ch.ready);
        @(posedge clk);
        sb.note_request(r);
    endtask

    // Idle gap with junk on the payload lines.
    task automatic idle_cycles(input int unsigned n);
        if (n == 0)
            return;
        pose_ch.valid <= 1'b0;
        drive_payload(random_pose_pair());
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        pose_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Result monitor: values are stable at the falling edge ahead of the accepting edge.
    always @(negedge clk)
    begin
        rel_pose_t got;
        if (rst_n === 1'b1 && rel_ch.valid === 1'b1 && rel_ch.ready === 1'b1)
        begin
            got.rel_pos_x = rel_ch.rel_pos_x;
            got.rel_pos_y = rel_ch.rel_pos_y;
            got.rel_pos_z = rel_ch.rel_pos_z;
            got.rel_quat  = rel_ch.rel_quat;
            got.saturated = rel_ch.saturated;
            sb.check_result(got);
        end
    end

    // Receiver: stall pattern changes per segment; one long hold-off on request.
    initial
    begin
        int unsigned seg_left;
        int unsigned hold_left;
        int unsigned period;
        int unsigned phase;
        rx_mode_e    stall_mode;
        rel_ch.ready = 1'b0;
        seg_left = 0;
        hold_left = 0;
        period = 2;
        phase = 0;
        stall_mode = RX_ALWAYS;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && hold_left == 0)
                hold_left = LONG_HOLD_CYCLES;
            if (hold_left != 0)
            begin
                rel_ch.ready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    long_hold_req = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    stall_mode = rx_mode_e'($urandom_range(0, 3));
                    period = $urandom_range(2, 5);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                phase++;
                case (stall_mode)
                    RX_ALWAYS:   rel_ch.ready <= 1'b1;
                    RX_LIGHT:    rel_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY:    rel_ch.ready <= ($urandom_range(0, 9) < 3);
                    default:     rel_ch.ready <= ((phase % period) == 0);
                endcase
            end
        end
    end

    // Reset, directed requests, then random bursts.
    initial
    begin
        pose_req_t   directed_reqs [$];
        pose_req_t   ident;
        int unsigned burst_left;
        int unsigned n;

        sb = new();
        rst_n = 1'b0;
        pose_ch.valid     = 1'b0;
        pose_ch.ref_pos_x = '0;
        pose_ch.ref_pos_y = '0;
        pose_ch.ref_pos_z = '0;
        pose_ch.ref_quat  = '0;
        pose_ch.tgt_pos_x = '0;
        pose_ch.tgt_pos_y = '0;
        pose_ch.tgt_pos_z = '0;
        pose_ch.tgt_quat  = '0;

        // Everything zero, including both quaternions.
        directed_reqs.push_back(pose_req_t'{0, 0, 0, 0, 0, 0, 0, 0});
        // Identity orientation with a plain offset.
        ident = pose_req_t'{0, 0, 0, quat4(QONE, 0, 0, 0),
                            PONE, 2 * PONE, 3 * PONE, quat4(QONE, 0, 0, 0)};
        directed_reqs.push_back(ident);
        // Position difference beyond the 32-bit range, both directions.
        directed_reqs.push_back(pose_req_t'{POS_MIN, POS_MIN, POS_MIN, quat4(QONE, 0, 0, 0),
                                            POS_MAX, POS_MAX, POS_MAX, quat4(QONE, 0, 0, 0)});
        directed_reqs.push_back(pose_req_t'{POS_MAX, POS_MAX, POS_MAX, quat4(QONE, 0, 0, 0),
                                            POS_MIN, POS_MIN, POS_MIN, quat4(QONE, 0, 0, 0)});
        // Most negative parts, whose conjugate does not fit in 16 bits.
        directed_reqs.push_back(pose_req_t'{PONE, -PONE, 0,
                                            quat4(QP_MIN, QP_MIN, QP_MIN, QP_MIN),
                                            0, PONE, -PONE, quat4(QONE, 0, 0, 0)});
        directed_reqs.push_back(pose_req_t'{0, 0, 0, quat4(QP_MIN, 0, 0, 0),
                                            PONE, 0, 0, quat4(QP_MIN, 0, 0, 0)});
        directed_reqs.push_back(pose_req_t'{0, 0, 0, quat4(0, QP_MIN, 0, 0),
                                            0, PONE, 0, quat4(0, QP_MIN, 0, 0)});
        // Largest parts everywhere with extreme positions, then largest against most negative parts.
        directed_reqs.push_back(pose_req_t'{POS_MIN, POS_MAX, POS_MIN,
                                            quat4(QP_MAX, QP_MAX, QP_MAX, QP_MAX),
                                            POS_MAX, POS_MIN, POS_MAX,
                                            quat4(QP_MAX, QP_MAX, QP_MAX, QP_MAX)});
        directed_reqs.push_back(pose_req_t'{0, 0, 0, quat4(QP_MAX, QP_MAX, QP_MAX, QP_MAX),
                                            PONE, PONE, PONE,
                                            quat4(QP_MIN, QP_MIN, QP_MIN, QP_MIN)});
        // Half turn about x against a target turned about y.
        directed_reqs.push_back(pose_req_t'{-PONE, PONE / 2, 0, quat4(0, QONE, 0, 0),
                                            PONE, 2 * PONE, 3 * PONE, quat4(0, 0, QONE, 0)});
        // Quarter turn about z.
        directed_reqs.push_back(pose_req_t'{0, 0, 0, quat4(16'sd11585, 0, 0, 16'sd11585),
                                            PONE, 0, 0, quat4(QONE, 0, 0, 0)});
        // Exact halfway cases in position and orientation, rounded upward.
        directed_reqs.push_back(pose_req_t'{0, 0, 0, quat4(16'sd1, 0, 16'sd1, 0),
                                            32'sh0400_0000, 0, 0, quat4(16'sd8192, 0, 0, 0)});
        directed_reqs.push_back(pose_req_t'{0, 0, 0, quat4(16'sd1, 0, 16'sd1, 0),
                                            -32'sh0400_0000, 0, 0,
                                            quat4(-16'sd8192, 0, 0, 0)});
        // All bits set on every field.
        directed_reqs.push_back(pose_req_t'{-1, -1, -1, '1, -1, -1, -1, '1});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_reqs[i])
            send_request(directed_reqs[i]);
        drain_results();

        burst_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Sender waits for the pipeline to empty once.
            if (n == DRAIN_AT)
                drain_results();
            // Receiver goes quiet while requests keep coming back to back.
            if (n == HOLD_AT)
                long_hold_req = 1'b1;
            if (burst_left == 0)
            begin
                if (!long_hold_req)
                    idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 25);
            end
            burst_left--;
            send_request(random_pose_pair());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/rpr_pkg.sv
sv/rpr_pose_if.sv
sv/rpr_rel_if.sv
sv/rpr_row_dot.sv
sv/relative_pose_to_reference_frame.sv
sim/rpr_tb_pkg.sv
sim/tb.sv
